@@ design/flc_pkg.sv @@
// Shared constants and types for the approximate single-precision logarithm.
package flc_pkg;

	// Single-precision format
	localparam int SGL_BIAS   = 127;
	localparam int SGL_MANT_W = 23;

	// ln2 as a 64-bit binary fraction
	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

	// Signed width of k (biased exponent minus 126)
	localparam int K_W = 9;

	// Headroom bits of the accumulator above the fraction bits
	localparam int ACC_GUARD = 8;

	// Stages of the series datapath, and of the whole pipeline up to the output
	localparam int CORE_DEPTH = 12;
	localparam int PIPE_DEPTH = 15;

	// One finished result beat
	typedef struct packed {
		logic [31:0] log_bits;
		logic        invalid;
	} result_t;

endpackage

@@ design/flc_mul.sv @@
// Two-stage fixed-point multiplier: a*b scaled down by 2^F, rounded half up.
module flc_mul #(
	parameter int FRAC_BITS = 30
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] a,
	input  logic [FRAC_BITS-1:0] b,
	output logic [FRAC_BITS-1:0] y
);

	localparam int SL = FRAC_BITS / 2;
	localparam int SH = FRAC_BITS - SL;
	localparam int HI_W = FRAC_BITS + SH;
	localparam int LO_W = FRAC_BITS + SL + 1;
	localparam int SUM_W = HI_W + 1;
	localparam logic [LO_W-1:0] RND = LO_W'(1) << (FRAC_BITS - 1);

	logic [HI_W-1:0]      hi_s1;
	logic [LO_W-1:0]      lo_s1;
	logic [SUM_W-1:0]     sum;
	logic [FRAC_BITS-1:0] y_s2;

	// Form the two partial products, rounding constant folded into the low one
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= HI_W'(a) * HI_W'(b[FRAC_BITS-1:SL]);
			lo_s1 <= LO_W'(a) * LO_W'(b[SL-1:0]) + RND;
		end
	end

	// Combine and drop the fraction bits
	assign sum = SUM_W'(hi_s1) + SUM_W'(lo_s1 >> SL);

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= FRAC_BITS'(sum >> SH);
		end
	end

	assign y = y_s2;

endmodule

@@ design/flc_f2s.sv @@
// Three-stage conversion of the signed fixed-point sum to single, round to nearest even.
module flc_f2s #(
	parameter int FRAC_BITS = 30
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic signed [FRAC_BITS+flc_pkg::ACC_GUARD-1:0] r,
	input  logic                                     inv,
	output flc_pkg::result_t                         res
);

	localparam int AW = FRAC_BITS + flc_pkg::ACC_GUARD;
	localparam int PW = $clog2(AW);
	localparam logic [PW-1:0] TOP_POS = PW'(AW - 1);
	localparam int MW = flc_pkg::SGL_MANT_W + 1;

	logic          sgn_s13, kill_s13;
	logic [AW-1:0] mag_s13;
	logic          sgn_s14, kill_s14;
	logic [AW-1:0] mag_s14;
	logic [PW-1:0] pos_s14;
	logic          sgn_s15, kill_s15;
	logic [AW-1:0] norm_s15;
	logic [7:0]    exp_s15;

	logic [PW-1:0] pos;
	logic [MW-1:0] mant;
	logic          guard, sticky, rnd;
	logic [MW:0]   mant_r;
	logic [7:0]    exp_out;
	logic [flc_pkg::SGL_MANT_W-1:0] frac_out;

	// Take sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s13  <= r[AW-1];
			mag_s13  <= r[AW-1] ? AW'(-r) : AW'(r);
			kill_s13 <= inv || (r == '0);
		end
	end

	// Find the leading one
	always_comb begin
		pos = '0;
		for (int i = 0; i < AW; i++) begin
			if (mag_s13[i]) begin
				pos = PW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s14  <= sgn_s13;
			kill_s14 <= kill_s13;
			mag_s14  <= mag_s13;
			pos_s14  <= pos;
		end
	end

	// Normalise so that the leading one sits in the top bit
	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s15  <= sgn_s14;
			kill_s15 <= kill_s14;
			norm_s15 <= mag_s14 << (TOP_POS - pos_s14);
			exp_s15  <= 8'(int'(pos_s14) + flc_pkg::SGL_BIAS - FRAC_BITS);
		end
	end

	// Round to nearest even and pack
	always_comb begin
		mant   = norm_s15[AW-1 -: MW];
		guard  = norm_s15[AW-1-MW];
		sticky = |norm_s15[AW-2-MW:0];
		rnd    = guard && (sticky || mant[0]);
		mant_r = (MW+1)'(mant) + (MW+1)'(rnd);
		if (mant_r[MW]) begin
			exp_out  = exp_s15 + 8'd1;
			frac_out = '0;
		end else begin
			exp_out  = exp_s15;
			frac_out = mant_r[flc_pkg::SGL_MANT_W-1:0];
		end
		res.invalid = 1'b0;
		if (kill_s15) begin
			res.log_bits = '0;
		end else begin
			res.log_bits = {sgn_s15, exp_out, frac_out};
		end
	end

endmodule

@@ design/flc_out.sv @@
// Output register with one skid entry, so the pipeline keeps moving while a single result waits.
module flc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  flc_pkg::result_t in_res,
	output logic             stall,
	output logic             m_tvalid,
	input  logic             m_tready,
	output flc_pkg::result_t out_res
);

	logic             out_vld_q;
	logic             skid_vld_q;
	flc_pkg::result_t out_q;
	flc_pkg::result_t skid_q;

	assign stall    = skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign out_res  = out_q;

	// Track occupancy of the output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_vld) begin
			if (out_vld_q && !m_tready) begin
				skid_vld_q <= 1'b1;
			end
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Move the payload: skid drains first, new beats land in the free slot
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (in_vld) begin
			if (out_vld_q && !m_tready) begin
				skid_q <= in_res;
			end else begin
				out_q <= in_res;
			end
		end
	end

	// The skid entry fills only behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid without output beat");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid entry filled while output was free");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && m_tready |=> !skid_vld_q && out_vld_q)
		else $error("skid entry did not drain into output");

endmodule

@@ design/float_log_approx_top.sv @@
// Top level of the pipelined approximate natural logarithm for single-precision operands.
//
// Usage:
//   Slave channel s_*: one single-precision operand per beat in s_tdata.
//   Master channel m_*: m_tdata carries the single bits of ln(x); m_tuser flags an
//   operand that is negative, zero, subnormal, infinite or NaN, with m_tdata zero.
//   The exponent is split off (k = e - 126), the mantissa mapped to c in [-0.5, 0),
//   and k*ln2 plus a fifth-order series in c is summed in fixed point with
//   FRAC_BITS fraction bits, then rounded to single, nearest even.
// Pipeline: an operand beat that is taken runs through stages s1 to s15 (five chained
//   two-stage multipliers, then a three-stage normalise and round) and lands in the
//   output register, which drives m_tvalid.
// Throughput: one beat per cycle while s_tready is high; every stage takes a new operand each cycle unless stalled.
// Reset: arst_n clears every valid bit; the pipeline and output are empty after it.
// Stall: a held result sits in the output register; the next one drops into a
//   single skid entry, and only while that entry is full does s_tready fall and
//   the whole pipeline hold. No beat is lost or repeated.
module float_log_approx_top #(
	parameter int FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] x_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] log_bits
	output logic [0:0]  m_tuser    // [0] invalid
);

	localparam int F  = FRAC_BITS;
	localparam int AW = F + flc_pkg::ACC_GUARD;
	localparam int KW = flc_pkg::K_W;
	localparam int CD = flc_pkg::CORE_DEPTH;
	localparam int PD = flc_pkg::PIPE_DEPTH;

	// Fixed-point constants, rounded half up
	localparam logic [63:0] ONE_Q = 64'd1 << F;
	localparam logic [F-1:0] COEF_THIRD  = F'((ONE_Q * 64'd2 + 64'd3) / 64'd6);
	localparam logic [F-1:0] COEF_FOURTH = F'((ONE_Q * 64'd22 + 64'd40) / 64'd80);
	localparam logic [F-1:0] COEF_FIFTH  = F'((ONE_Q * 64'd274 + 64'd500) / 64'd1000);
	localparam logic [F-1:0] LN2_Q =
		F'((flc_pkg::LN2_Q64 + (64'd1 << (63 - F))) >> (64 - F));

	logic en, stall;
	logic [PD:1] pipe_vld_q;
	logic [CD:1] pipe_inv_q;

	logic [7:0]  x_exp;
	logic [22:0] x_man;
	logic        x_inv;
	logic [23:0] a_raw;
	logic [F-1:0] a_q_in;

	logic [F-1:0] a_q_s1, a_q_s2, a_q_s3, a_q_s4, a_q_s5, a_q_s6, a_q_s7;
	logic signed [KW-1:0] k_s1;
	logic signed [AW-1:0] kln_s2, kln_s3;
	logic signed [AW-1:0] acc_s4, acc_s5, acc_s6, acc_s7, acc_s8;
	logic signed [AW-1:0] acc_s9, acc_s10, acc_s11, acc_s12;
	logic [F-1:0] p2_s3, p3_s5, p4_s7, p5_s9;
	logic [F-1:0] t2_s4, t3_s7, t4_s9, t5_s11;

	flc_pkg::result_t conv_res, out_res;

	assign en       = !stall;
	assign s_tready = en;

	// Decode the operand
	assign x_exp = s_tdata[30:23];
	assign x_man = s_tdata[22:0];
	assign x_inv = s_tdata[31] || (x_exp == 8'h00) || (x_exp == 8'hFF);
	assign a_raw = 24'h800000 - 24'(x_man);

	// Scale A = -c to F fraction bits
	generate
		if (F >= 24) begin : g_a_up
			assign a_q_in = F'(a_raw) << (F - 24);
		end else begin : g_a_down
			logic [24:0] a_rnd;
			assign a_rnd  = 25'(a_raw) + (25'd1 << (23 - F));
			assign a_q_in = F'(a_rnd >> (24 - F));
		end
	endgenerate

	// Advance the valid and invalid-flag lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
		end else if (en) begin
			pipe_vld_q <= {pipe_vld_q[PD-1:1], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_inv_q <= {pipe_inv_q[CD-1:1], x_inv};
		end
	end

	// Series datapath: carry A along, fold each term into the accumulator
	always_ff @(posedge clk) begin
		if (en) begin
			a_q_s1  <= a_q_in;
			k_s1    <= $signed(KW'(x_exp) - KW'(126));
			a_q_s2  <= a_q_s1;
			kln_s2  <= AW'(k_s1 * $signed({1'b0, LN2_Q}));
			a_q_s3  <= a_q_s2;
			kln_s3  <= kln_s2;
			a_q_s4  <= a_q_s3;
			t2_s4   <= F'(((F + 1)'(p2_s3) + (F + 1)'(1)) >> 1);
			acc_s4  <= kln_s3 - $signed(AW'(a_q_s3));
			a_q_s5  <= a_q_s4;
			acc_s5  <= acc_s4 - $signed(AW'(t2_s4));
			a_q_s6  <= a_q_s5;
			acc_s6  <= acc_s5;
			a_q_s7  <= a_q_s6;
			acc_s7  <= acc_s6;
			acc_s8  <= acc_s7 - $signed(AW'(t3_s7));
			acc_s9  <= acc_s8;
			acc_s10 <= acc_s9 - $signed(AW'(t4_s9));
			acc_s11 <= acc_s10;
			acc_s12 <= acc_s11 - $signed(AW'(t5_s11));
		end
	end

	// Power chain and coefficient products
	flc_mul #(.FRAC_BITS(F)) u_mul_p2 (
		.clk(clk), .en(en), .a(a_q_s1), .b(a_q_s1), .y(p2_s3));
	flc_mul #(.FRAC_BITS(F)) u_mul_p3 (
		.clk(clk), .en(en), .a(p2_s3), .b(a_q_s3), .y(p3_s5));
	flc_mul #(.FRAC_BITS(F)) u_mul_p4 (
		.clk(clk), .en(en), .a(p3_s5), .b(a_q_s5), .y(p4_s7));
	flc_mul #(.FRAC_BITS(F)) u_mul_t3 (
		.clk(clk), .en(en), .a(p3_s5), .b(COEF_THIRD), .y(t3_s7));
	flc_mul #(.FRAC_BITS(F)) u_mul_p5 (
		.clk(clk), .en(en), .a(p4_s7), .b(a_q_s7), .y(p5_s9));
	flc_mul #(.FRAC_BITS(F)) u_mul_t4 (
		.clk(clk), .en(en), .a(p4_s7), .b(COEF_FOURTH), .y(t4_s9));
	flc_mul #(.FRAC_BITS(F)) u_mul_t5 (
		.clk(clk), .en(en), .a(p5_s9), .b(COEF_FIFTH), .y(t5_s11));

	// Convert to single
	flc_f2s #(.FRAC_BITS(F)) u_f2s (
		.clk(clk),
		.en(en),
		.r(acc_s12),
		.inv(pipe_inv_q[CD]),
		.res(conv_res)
	);

	// Hand the flag over alongside the packed word
	flc_pkg::result_t last_res;
	logic             inv_s13, inv_s14, inv_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s13 <= pipe_inv_q[CD];
			inv_s14 <= inv_s13;
			inv_s15 <= inv_s14;
		end
	end

	always_comb begin
		last_res         = conv_res;
		last_res.invalid = inv_s15;
	end

	flc_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(pipe_vld_q[PD] && en),
		.in_res(last_res),
		.stall(stall),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata    = out_res.log_bits;
	assign m_tuser[0] = out_res.invalid;

	// An invalid operand always yields a zero word
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("invalid result carries non-zero data");

	// A valid result is always finite
	a_finite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[30:23] != 8'hFF)
		else $error("result exponent saturated");

	// The pipeline holds its valid bits while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(pipe_vld_q))
		else $error("pipeline moved during a stall");

endmodule

@@ dv/tb_float_log_approx_top.sv @@
// Self-checking testbench for the pipelined approximate single-precision logarithm.
module tb_float_log_approx_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS   = 30;
	localparam int CLK_HALF    = 4;
	localparam int RESET_CYC   = 12;
	localparam int N_RANDOM    = 650;
	localparam int CALM_TAIL   = 60;
	localparam int STALL_LIMIT = 4000;

	// Fixed-point constants of the series, scaled by 2^FRAC_BITS and rounded half up
	localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;
	localparam logic [63:0] COEF_HALF   = ONE_Q >> 1;
	localparam logic [63:0] COEF_THIRD  = (ONE_Q * 2 + 3) / 6;
	localparam logic [63:0] COEF_FOURTH = (ONE_Q * 22 + 40) / 80;
	localparam logic [63:0] COEF_FIFTH  = (ONE_Q * 274 + 500) / 1000;
	localparam logic [63:0] LN2_Q       =
		(flc_pkg::LN2_Q64 + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS);
	localparam int A_UP = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
	localparam int A_DN = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 1;

	typedef struct {
		logic [31:0] bits;
		logic        drain;   // hold this operand back until every result is in
	} operand_t;

	typedef struct {
		logic [31:0]      operand;
		flc_pkg::result_t res;
	} log_pending_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	operand_t     operand_q[$];
	log_pending_t log_expected[$];
	int           ops_issued   = 0;
	int           ops_accepted = 0;
	int           err_count    = 0;
	int           quiet_cycles = 0;

	float_log_approx_top #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Round half up of a*b / 2^FRAC_BITS
	function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b) + (128'd1 << (FRAC_BITS - 1));
		return 64'(prod >> FRAC_BITS);
	endfunction

	// Convert a signed fixed-point sum to single bits, round to nearest even
	function automatic logic [31:0] fixed_to_sgl(input logic signed [63:0] acc);
		logic        sgn;
		logic [63:0] mag;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] mant;
		int          msb;
		int          sh;
		int          ex;
		if (acc == 0)
			return 32'd0;
		sgn = acc[63];
		mag = sgn ? 64'(-acc) : 64'(acc);
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (mag[i])
				msb = i;
		ex = msb - FRAC_BITS + flc_pkg::SGL_BIAS;
		if (msb <= flc_pkg::SGL_MANT_W) begin
			mant = mag << (flc_pkg::SGL_MANT_W - msb);
		end else begin
			sh   = msb - flc_pkg::SGL_MANT_W;
			rem  = mag & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			mant = mag >> sh;
			if (rem > half || (rem == half && mant[0]))
				mant++;
			if (mant[24]) begin
				mant = mant >> 1;
				ex++;
			end
		end
		return {sgn, ex[7:0], mant[22:0]};
	endfunction

	// Expected result for one operand
	function automatic flc_pkg::result_t flog_predict(input logic [31:0] x);
		flc_pkg::result_t   r;
		logic [7:0]         e;
		logic [63:0]        a;
		logic [63:0]        aq;
		logic [63:0]        p2;
		logic [63:0]        p3;
		logic [63:0]        p4;
		logic [63:0]        p5;
		logic [63:0]        poly;
		longint             k;
		logic signed [63:0] acc;
		e = x[30:23];
		if (x[31] || e == 8'd0 || e == 8'hFF) begin
			r.log_bits = 32'd0;
			r.invalid  = 1'b1;
			return r;
		end
		k = longint'(e) - 126;
		a = (64'd1 << 23) - 64'(x[22:0]);
		if (FRAC_BITS >= 24)
			aq = a << A_UP;
		else
			aq = (a + (64'd1 << (A_DN - 1))) >> A_DN;
		p2   = mul_round(aq, aq);
		p3   = mul_round(p2, aq);
		p4   = mul_round(p3, aq);
		p5   = mul_round(p4, aq);
		poly = aq + mul_round(p2, COEF_HALF) + mul_round(p3, COEF_THIRD) +
			mul_round(p4, COEF_FOURTH) + mul_round(p5, COEF_FIFTH);
		acc  = k * longint'(LN2_Q) - longint'(poly);
		r.log_bits = fixed_to_sgl(acc);
		r.invalid  = 1'b0;
		return r;
	endfunction

	// Random operand, weighted towards positive normals
	function automatic logic [31:0] rand_operand();
		logic [7:0] ex_pick[7];
		ex_pick = '{8'd1, 8'd2, 8'd126, 8'd127, 8'd128, 8'd253, 8'd254};
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return {1'b0, ex_pick[$urandom_range(0, 6)], 23'($urandom)};
			3: return {1'($urandom), ($urandom_range(0, 1) ? 8'hFF : 8'h00), 23'($urandom)};
			default: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic push_operand(input logic [31:0] bits, input logic drain);
		operand_t op;
		op.bits  = bits;
		op.drain = drain;
		operand_q.push_back(op);
	endtask

	// Source side: present operands at the falling edge, idle in random bursts
	int src_idle_left = 0;
	int src_idle_pct  = 0;
	int src_cyc       = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			src_cyc++;
			if (src_cyc % 64 == 0)
				src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			if (!s_tvalid || ops_accepted == ops_issued) begin
				if (src_idle_left > 0) begin
					s_tvalid <= 1'b0;
					src_idle_left--;
				end else if (operand_q.size() > CALM_TAIL &&
						$urandom_range(0, 99) < src_idle_pct) begin
					s_tvalid <= 1'b0;
					src_idle_left = $urandom_range(1, 12) - 1;
				end else if (operand_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (operand_q[0].drain && log_expected.size() != 0) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tdata  <= operand_q[0].bits;
					s_tvalid <= 1'b1;
					void'(operand_q.pop_front());
					ops_issued++;
				end
			end
		end
	end

	// Sink side: stall in random bursts, none in the closing stretch
	int snk_stall_left = 0;
	int snk_stall_pct  = 0;
	int snk_cyc        = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			snk_cyc++;
			if (snk_cyc % 48 == 0)
				snk_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			if (snk_stall_left > 0) begin
				m_tready <= 1'b0;
				snk_stall_left--;
			end else if (operand_q.size() > CALM_TAIL &&
					$urandom_range(0, 99) < snk_stall_pct) begin
				m_tready <= 1'b0;
				snk_stall_left = $urandom_range(1, 12) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Sample both channels at the rising edge: predict on input beats, check output beats
	always @(posedge clk) begin
		log_pending_t pend;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (log_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected beat data=%h invalid=%b",
						m_tdata, m_tuser[0]));
				end else begin
					pend = log_expected.pop_front();
					if (m_tdata !== pend.res.log_bits)
						report_mismatch($sformatf("x=%h log_bits got %h want %h",
							pend.operand, m_tdata, pend.res.log_bits));
					if (m_tuser[0] !== pend.res.invalid)
						report_mismatch($sformatf("x=%h invalid got %b want %b",
							pend.operand, m_tuser[0], pend.res.invalid));
				end
			end
			if (s_tvalid && s_tready) begin
				pend.operand = s_tdata;
				pend.res     = flog_predict(s_tdata);
				log_expected.push_back(pend);
				ops_accepted++;
			end
			// Watchdog on cycles with no beat on either side
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_float_log_approx_top: errors");
				$finish;
			end
		end
	end

	initial begin
		// Directed operands: field extremes and every invalid class
		push_operand(32'h3F80_0000, 1'b0);   // 1.0
		push_operand(32'h3F00_0000, 1'b0);   // 0.5, k = 0
		push_operand(32'h3FFF_FFFF, 1'b0);   // mantissa all ones
		push_operand(32'h0080_0000, 1'b0);   // smallest normal
		push_operand(32'h00FF_FFFF, 1'b0);
		push_operand(32'h7F7F_FFFF, 1'b0);   // largest normal
		push_operand(32'h7F00_0000, 1'b0);
		push_operand(32'h3F7F_FFFF, 1'b0);   // just below one
		push_operand(32'h4000_0000, 1'b0);   // 2.0
		push_operand(32'h3F80_0001, 1'b0);   // just above one
		push_operand(32'h402D_F854, 1'b0);   // close to e
		push_operand(32'h0000_0000, 1'b0);   // +0
		push_operand(32'h8000_0000, 1'b0);   // -0
		push_operand(32'h0000_0001, 1'b0);   // subnormal
		push_operand(32'h007F_FFFF, 1'b0);   // largest subnormal
		push_operand(32'h7F80_0000, 1'b0);   // +inf
		push_operand(32'hFF80_0000, 1'b0);   // -inf
		push_operand(32'h7FC0_0000, 1'b0);   // quiet NaN
		push_operand(32'h7F80_0001, 1'b0);   // signalling NaN
		push_operand(32'hBF80_0000, 1'b0);   // -1.0
		push_operand(32'hFFFF_FFFF, 1'b0);
		push_operand(32'h5555_5555, 1'b0);
		push_operand(32'h2AAA_AAAA, 1'b0);
		// Random operands, with a full drain before the first and at a mid point
		for (int n = 0; n < N_RANDOM; n++)
			push_operand(rand_operand(), (n == 0 || n == N_RANDOM / 2));

		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;

		// Wait for all operands to go in, then for every result
		while (operand_q.size() != 0 || ops_accepted != ops_issued || s_tvalid)
			@(posedge clk);
		while (log_expected.size() != 0)
			@(posedge clk);
		repeat (flc_pkg::PIPE_DEPTH + 10) @(posedge clk);

		if (err_count == 0)
			$display("tb_float_log_approx_top: clean");
		else
			$display("tb_float_log_approx_top: errors");
		$finish;
	end

endmodule
